FILE: sv/gmhbp_pkg.sv
package gmhbp_pkg;

    // Field widths fixed by the event and result formats
    localparam int OP_W     = 2;
    localparam int POS_W    = 30;
    localparam int VAL_W    = 30;
    localparam int NEED_W   = POS_W + 1;
    localparam int PWR_W    = 48;
    localparam int PICK_W   = 11;
    localparam int STATUS_W = 2;

    localparam int HEAP_DEPTH_DEF = 1024;

    localparam logic [PWR_W-1:0]  PWR_MAX  = {PWR_W{1'b1}};
    localparam logic [PICK_W-1:0] PICK_MAX = {PICK_W{1'b1}};

    // Event opcodes
    localparam logic [OP_W-1:0] OP_BOOST   = 2'd0;
    localparam logic [OP_W-1:0] OP_BARRIER = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Case status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNREACH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [VAL_W-1:0] value;
    } heap_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] top;
    } heap_rsp_t;

endpackage

FILE: sv/gmhbp_heap.sv
module gmhbp_heap
    import gmhbp_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    localparam int AW = $clog2(HEAP_DEPTH),
    localparam int CW = $clog2(HEAP_DEPTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  heap_req_t       req,
    output heap_rsp_t       rsp,
    output logic [CW-1:0]   heap_count
);

    localparam int XW = AW + 2;

    typedef enum logic [3:0] {
        H_IDLE,
        H_PU_STEP,
        H_PU_CMP,
        H_PO_TOP,
        H_PO_LAST,
        H_PO_LASTW,
        H_PO_CH,
        H_PO_CH1,
        H_PO_CH2
    } heap_state_t;

    heap_state_t      state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    par_reg, par_next;
    logic [AW-1:0]    cidx_reg, cidx_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] cval_reg, cval_next;
    logic [VAL_W-1:0] top_reg, top_next;
    logic             done_reg, done_next;

    logic [VAL_W-1:0] mem_q [HEAP_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic [AW-1:0]    parent;
    logic [XW-1:0]    child1;
    logic [XW-1:0]    child2;
    logic [XW-1:0]    cnt_x;
    logic             right_wins;
    logic [VAL_W-1:0] best_val;
    logic [AW-1:0]    best_idx;

    assign parent     = (idx_reg - AW'(1)) >> 1;
    assign child1     = {1'b0, idx_reg, 1'b1};
    assign child2     = child1 + XW'(1);
    assign cnt_x      = XW'(count_reg);
    assign right_wins = rd_data_reg > cval_reg;
    assign best_val   = right_wins ? rd_data_reg : cval_reg;
    assign best_idx   = right_wins ? child2[AW-1:0] : cidx_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        par_next   = par_reg;
        cidx_next  = cidx_reg;
        val_next   = val_reg;
        cval_next  = cval_reg;
        top_next   = top_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = val_reg;

        unique case (state_reg)
            H_IDLE:
            begin
                if (req.clear)
                begin
                    count_next = '0;
                end
                else if (req.push)
                begin
                    val_next   = req.value;
                    idx_next   = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    state_next = H_PU_STEP;
                end
                else if (req.pop)
                begin
                    state_next = H_PO_TOP;
                end
            end
            // Sift up: fetch parent
            H_PU_STEP:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    par_next   = parent;
                    state_next = H_PU_CMP;
                end
            end
            H_PU_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg >= val_reg)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = par_reg;
                    state_next = H_PU_STEP;
                end
            end
            H_PO_TOP:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                count_next = count_reg - CW'(1);
                state_next = H_PO_LAST;
            end
            H_PO_LAST:
            begin
                top_next = rd_data_reg;
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = count_reg[AW-1:0];
                    state_next = H_PO_LASTW;
                end
            end
            H_PO_LASTW:
            begin
                val_next   = rd_data_reg;
                idx_next   = '0;
                state_next = H_PO_CH;
            end
            // Sift down: fetch left child, then right child if present
            H_PO_CH:
            begin
                if (child1 >= cnt_x)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child1[AW-1:0];
                    state_next = H_PO_CH1;
                end
            end
            H_PO_CH1:
            begin
                cval_next = rd_data_reg;
                cidx_next = child1[AW-1:0];
                if (child2 < cnt_x)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child2[AW-1:0];
                    state_next = H_PO_CH2;
                end
                else if (rd_data_reg <= val_reg)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data_reg;
                    idx_next   = child1[AW-1:0];
                    state_next = H_PO_CH;
                end
            end
            H_PO_CH2:
            begin
                wr_en = 1'b1;
                if (best_val <= val_reg)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    wr_data    = best_val;
                    idx_next   = best_idx;
                    state_next = H_PO_CH;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            par_reg   <= '0;
            cidx_reg  <= '0;
            val_reg   <= '0;
            cval_reg  <= '0;
            top_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            par_reg   <= par_next;
            cidx_reg  <= cidx_next;
            val_reg   <= val_next;
            cval_reg  <= cval_next;
            top_reg   <= top_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.top    = top_reg;
    assign heap_count = count_reg;

endmodule

FILE: sv/greedy_max_heap_boost_picker_unit.sv
// Boost event: the heap sifts the new boost up L levels, to the root or to a place below it,
// L = levels climbed (<= log2 depth).
// Barrier event: one heap pop per boost picked, each sifting down L levels; a pick that empties
// the heap needs no sift. Clear, ignored and unused-opcode events report their result directly.
// One event in flight; the next transfer in is taken as its result appears, and a result still
// held in the output register stalls the sequencer. Reset (rst_n, async, active low) empties the heap.
module greedy_max_heap_boost_picker_unit
    import gmhbp_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [POS_W-1:0]    position_start,
    input  logic [POS_W-1:0]    position_end,
    input  logic [VAL_W-1:0]    boost_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [PICK_W-1:0]   picks_taken
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    // S_IDLE      take the next event
    // S_PUSH_WAIT heap sifts the new boost up
    // S_BAR_CHECK compare power against the barrier need, pop or finish
    // S_POP_WAIT  heap removes its top and sifts down
    // S_DONE      hand the result to the output register once it is free
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WAIT,
        S_BAR_CHECK,
        S_POP_WAIT,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [PWR_W-1:0]     power_reg, power_next;
    logic [PICK_W-1:0]    picks_reg, picks_next;
    logic [STATUS_W-1:0]  case_st_reg, case_st_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_out_reg, status_out_next;
    logic [PICK_W-1:0]    picks_out_reg, picks_out_next;

    heap_req_t            heap_req;
    heap_rsp_t            heap_rsp;
    logic [CW-1:0]        heap_count;

    logic                 in_xfer;
    logic                 heap_full;
    logic [NEED_W-1:0]    need_calc;
    logic [PWR_W:0]       power_sum;

    assign in_xfer   = in_valid && in_ready;
    assign heap_full = heap_count >= CW'(HEAP_DEPTH);
    // Barrier length, inclusive of both ends
    assign need_calc = {1'b0, position_end} - {1'b0, position_start} + NEED_W'(1);
    // One extra bit catches the carry for power saturation
    assign power_sum = {1'b0, power_reg} + (PWR_W + 1)'(heap_rsp.top);

    always_comb
    begin
        state_next      = state_reg;
        power_next      = power_reg;
        picks_next      = picks_reg;
        case_st_next    = case_st_reg;
        need_next       = need_reg;
        out_valid_next  = out_valid_reg;
        status_out_next = status_out_reg;
        picks_out_next  = picks_out_reg;
        heap_req        = '0;
        heap_req.value  = boost_value;

        // Drop the held result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DONE;
                    if (opcode == OP_CLEAR)
                    begin
                        // New case: empty the heap, zero power and picks, reset the status
                        heap_req.clear = 1'b1;
                        power_next     = '0;
                        picks_next     = '0;
                        case_st_next   = ST_OK;
                    end
                    else if (case_st_reg == ST_OK)
                    begin
                        if (opcode == OP_BOOST)
                        begin
                            if (heap_full)
                            begin
                                case_st_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                heap_req.push = 1'b1;
                                state_next    = S_PUSH_WAIT;
                            end
                        end
                        else if (opcode == OP_BARRIER)
                        begin
                            // A reversed barrier needs no power at all
                            if (position_end >= position_start)
                            begin
                                need_next  = need_calc;
                                state_next = S_BAR_CHECK;
                            end
                        end
                    end
                    // A faulted case and the unused opcode just report the result
                end
            end
            S_PUSH_WAIT:
            begin
                if (heap_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_BAR_CHECK:
            begin
                if (power_reg >= PWR_W'(need_reg))
                begin
                    state_next = S_DONE;
                end
                else if (heap_count == '0)
                begin
                    // Heap ran dry: picks already taken stay counted
                    case_st_next = ST_UNREACH;
                    state_next   = S_DONE;
                end
                else
                begin
                    heap_req.pop = 1'b1;
                    state_next   = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                if (heap_rsp.done)
                begin
                    // Saturate power and picks, then test the need again
                    power_next = power_sum[PWR_W] ? PWR_MAX : power_sum[PWR_W-1:0];
                    if (picks_reg != PICK_MAX)
                    begin
                        picks_next = picks_reg + PICK_W'(1);
                    end
                    state_next = S_BAR_CHECK;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = case_st_reg;
                    picks_out_next  = picks_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            power_reg      <= '0;
            picks_reg      <= '0;
            case_st_reg    <= ST_OK;
            need_reg       <= '0;
            out_valid_reg  <= 1'b0;
            status_out_reg <= ST_OK;
            picks_out_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            power_reg      <= power_next;
            picks_reg      <= picks_next;
            case_st_reg    <= case_st_next;
            need_reg       <= need_next;
            out_valid_reg  <= out_valid_next;
            status_out_reg <= status_out_next;
            picks_out_reg  <= picks_out_next;
        end
    end

    gmhbp_heap #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (heap_req),
        .rsp        (heap_rsp),
        .heap_count (heap_count)
    );

    // Accept a new event only between events; the output register decouples the consumer
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_out_reg;
    assign picks_taken = picks_out_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        heap_req.pop |-> (heap_count != '0))
        else $error("pop requested on an empty heap");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        heap_req.push |-> (heap_count < CW'(HEAP_DEPTH)))
        else $error("push requested on a full heap");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        heap_rsp.done |-> (state_reg == S_PUSH_WAIT || state_reg == S_POP_WAIT))
        else $error("heap finished while no operation was pending");

    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (case_st_reg != ST_OK && !(in_xfer && opcode == OP_CLEAR))
        |=> (case_st_reg == $past(case_st_reg)))
        else $error("fault status changed without a clear");

endmodule
